>>> hw/rtl/usd_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
// Used by the front end, the back end and the top level; depends on nothing.

package usd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;

  // Lead and continuation byte classification masks and codes
  localparam logic [ByteW-1:0] AsciiMask = 8'h80;
  localparam logic [ByteW-1:0] ContMask  = 8'hc0;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'he0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hc0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hf0;
  localparam logic [ByteW-1:0] Lead3Code = 8'he0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hf8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hf0;

  // Replacement character after reset ('?')
  localparam logic [CpW-1:0] ReplResetValue = 21'd63;

  // One decode job: num_err error beats, then one final beat that is either
  // a code point or an error. The final beat closes the byte's run.
  typedef struct packed {
    logic [1:0]     num_err;
    logic           final_err;
    logic [CpW-1:0] value;
  } job_t;

endpackage

>>> hw/rtl/usd_fifo.sv
// Small flop-based queue of decode jobs between front and back end.
// Generic over width and depth; no package dependency.

module usd_fifo #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("job queue count exceeds depth");

endmodule

>>> hw/rtl/usd_front.sv
// Front end: takes input bytes, tracks the open sequence and turns each byte
// into at most one decode job. Depends on usd_pkg.

module usd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [usd_pkg::ByteW-1:0]        data_byte_i,
  input  logic                             buffer_last_i,
  output logic                             job_valid_o,
  output usd_pkg::job_t                    job_o
);

  logic [usd_pkg::CpW-1:0] partial_q, partial_d;
  logic [1:0]              rem_q, rem_d;
  logic [1:0]              rcv_q, rcv_d;
  logic [usd_pkg::ByteW-1:0] b;
  logic [usd_pkg::CpW-1:0] cont_value;
  logic                    is_ascii;

  assign b          = data_byte_i;
  assign is_ascii   = ((b & usd_pkg::AsciiMask) == '0);
  assign cont_value = {partial_q[usd_pkg::CpW-7:0], b[5:0]};

  // Classify the byte against the sequence state
  always_comb begin
    partial_d   = partial_q;
    rem_d       = rem_q;
    rcv_d       = rcv_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (rem_q == 2'd0) begin
      if (is_ascii) begin
        job_valid_o = 1'b1;
        job_o.value = usd_pkg::CpW'(b);
      end else if (buffer_last_i) begin
        job_valid_o     = 1'b1;
        job_o.final_err = 1'b1;
      end else if ((b & usd_pkg::Lead2Mask) == usd_pkg::Lead2Code) begin
        partial_d = usd_pkg::CpW'(b[4:0]);
        rem_d     = 2'd1;
        rcv_d     = 2'd0;
      end else if ((b & usd_pkg::Lead3Mask) == usd_pkg::Lead3Code) begin
        partial_d = usd_pkg::CpW'(b[3:0]);
        rem_d     = 2'd2;
        rcv_d     = 2'd0;
      end else if ((b & usd_pkg::Lead4Mask) == usd_pkg::Lead4Code) begin
        partial_d = usd_pkg::CpW'(b[2:0]);
        rem_d     = 2'd3;
        rcv_d     = 2'd0;
      end else begin
        job_valid_o     = 1'b1;
        job_o.final_err = 1'b1;
      end
    end else if (buffer_last_i && rem_q >= 2'd2) begin
      // Buffer ends early: error for the lead, one more if any continuation
      // came in, then the final byte on its own
      job_valid_o     = 1'b1;
      job_o.num_err   = (rcv_q != 2'd0) ? 2'd2 : 2'd1;
      job_o.final_err = !is_ascii;
      job_o.value     = usd_pkg::CpW'(b);
      partial_d       = '0;
      rem_d           = 2'd0;
      rcv_d           = 2'd0;
    end else if ((b & usd_pkg::ContMask) == usd_pkg::ContCode) begin
      if (rem_q == 2'd1) begin
        job_valid_o = 1'b1;
        job_o.value = cont_value;
        partial_d   = '0;
        rem_d       = 2'd0;
        rcv_d       = 2'd0;
      end else begin
        partial_d = cont_value;
        rem_d     = rem_q - 2'd1;
        rcv_d     = rcv_q + 2'd1;
      end
    end else begin
      // Broken sequence: drop it, consume the byte
      job_valid_o     = 1'b1;
      job_o.final_err = 1'b1;
      partial_d       = '0;
      rem_d           = 2'd0;
      rcv_d           = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      rem_q     <= 2'd0;
      rcv_q     <= 2'd0;
    end else if (accept_i) begin
      partial_q <= partial_d;
      rem_q     <= rem_d;
      rcv_q     <= rcv_d;
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == 2'd0 |-> (rcv_q == 2'd0 && partial_q == '0))
    else $error("idle decoder holds stale sequence state");

  a_seq_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rem_q} + {1'b0, rcv_q}) <= 3'd3)
    else $error("sequence length exceeds four bytes");

endmodule

>>> hw/rtl/usd_back.sv
// Back end: expands each decode job into result beats and holds the oldest
// beat in an output register. Depends on usd_pkg.

module usd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  usd_pkg::job_t           job_i,
  input  logic                    job_empty_i,
  output logic                    job_pop_o,
  input  logic [usd_pkg::CpW-1:0] repl_char_i,
  output logic                    empty_o,
  input  logic                    pop_i,
  output logic [usd_pkg::CpW-1:0] code_point_o,
  output logic                    decode_error_o,
  output logic                    run_last_o
);

  logic                    out_valid_q, out_valid_d;
  logic [usd_pkg::CpW-1:0] cp_q, cp_d;
  logic                    err_q, err_d;
  logic                    last_q, last_d;
  logic [1:0]              cnt_q, cnt_d;
  logic                    load;

  assign empty_o        = !out_valid_q;
  assign code_point_o   = cp_q;
  assign decode_error_o = err_q;
  assign run_last_o     = last_q;
  assign load           = !job_empty_i && (!out_valid_q || pop_i);

  // Pick the next beat of the head job; pop the job on its final beat
  always_comb begin
    out_valid_d = out_valid_q;
    cp_d        = cp_q;
    err_d       = err_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    job_pop_o   = 1'b0;
    if (out_valid_q && pop_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (cnt_q < job_i.num_err) begin
        cp_d   = repl_char_i;
        err_d  = 1'b1;
        last_d = 1'b0;
        cnt_d  = cnt_q + 2'd1;
      end else begin
        cp_d      = job_i.final_err ? repl_char_i : job_i.value;
        err_d     = job_i.final_err;
        last_d    = 1'b1;
        cnt_d     = 2'd0;
        job_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Hold the payload of the output beat
  always_ff @(posedge clk_i) begin
    cp_q   <= cp_d;
    err_q  <= err_d;
    last_q <= last_d;
  end

  a_partial_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd0 |-> (!job_empty_i && cnt_q <= job_i.num_err))
    else $error("partly expanded job lost from queue head");

endmodule

>>> hw/rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: replacement character register,
// front end, job queue and back end. Depends on usd_pkg, usd_front,
// usd_fifo and usd_back.
//
//   Port group              Dir  Handshake                 Beat
//   push/full               in   push && !full             data_byte_i, buffer_last_i
//   empty/pop               out  !empty && pop             code_point_o, decode_error_o,
//                                                           run_last_o
//   cfg_valid_i/cfg_ready_o in   cfg_valid_i && cfg_ready_o cfg_data_i (replacement char)
//
// One input byte per cycle is taken while the job queue has room; a byte
// gives zero or one job, decoded in the same cycle it is taken.
// The back end sends one result beat per cycle while the output is popped;
// a byte gives at most three results (when a buffer ends early).
// A byte's first result passes through the job queue, then the output register.
// Reset clears the sequence state, the queue and the output register and
// sets the replacement character to 63. A stalled output fills the queue
// and then raises full.

module utf8_stream_decoder #(
  parameter int unsigned JobDepth = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              data_byte_i,
  input  logic                    buffer_last_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [20:0]             code_point_o,
  output logic                    decode_error_o,
  output logic                    run_last_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [20:0]             cfg_data_i
);

  localparam int unsigned JobW = $bits(usd_pkg::job_t);

  logic [usd_pkg::CpW-1:0] repl_q;
  logic                    accept;
  logic                    job_valid;
  usd_pkg::job_t           job_in, job_head;
  logic [JobW-1:0]         job_rdata;
  logic                    job_full, job_empty, job_pop;

  assign cfg_ready_o = 1'b1;
  assign full        = job_full;
  assign accept      = push && !job_full;
  assign job_head    = usd_pkg::job_t'(job_rdata);

  // Replacement character register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= usd_pkg::ReplResetValue;
    end else if (cfg_valid_i && cfg_ready_o) begin
      repl_q <= cfg_data_i;
    end
  end

  usd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .buffer_last_i (buffer_last_i),
    .job_valid_o   (job_valid),
    .job_o         (job_in)
  );

  usd_fifo #(
    .Width (JobW),
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && job_valid),
    .wdata_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .empty_o (job_empty)
  );

  usd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_head),
    .job_empty_i    (job_empty),
    .job_pop_o      (job_pop),
    .repl_char_i    (repl_q),
    .empty_o        (empty),
    .pop_i          (pop),
    .code_point_o   (code_point_o),
    .decode_error_o (decode_error_o),
    .run_last_o     (run_last_o)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for utf8_stream_decoder: directed and random byte streams,
// an in-bench decoder that predicts every code point beat, random stalls on both sides.
// Depends on usd_pkg and the utf8_stream_decoder RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallCycles = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxPrinted = 100;

  typedef struct packed {
    logic [usd_pkg::ByteW-1:0] data;
    logic                      fin;
  } byte_beat_t;

  typedef struct packed {
    logic [usd_pkg::CpW-1:0] cp;
    logic                    err;
    logic                    run_last;
  } cp_beat_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic [usd_pkg::ByteW-1:0] data_byte_i = '0;
  logic                      buffer_last_i = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [usd_pkg::CpW-1:0]   code_point_o;
  logic                      decode_error_o;
  logic                      run_last_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [usd_pkg::CpW-1:0]   cfg_data_i = '0;

  // Stimulus and expectation stores
  byte_beat_t byte_queue[$];
  cp_beat_t   code_points_due[$];
  int         items_queued = 0;
  int         items_taken = 0;
  int         errors = 0;

  // Phase controls, written with nonblocking assignments by the sequencer
  logic gaps_on = 1'b1;
  logic squeeze = 1'b0;

  // Decoder state mirrored by the predictor
  logic [usd_pkg::CpW-1:0] repl_char = usd_pkg::ReplResetValue;
  logic [usd_pkg::CpW-1:0] seq_value = '0;
  logic [1:0]              seq_need = '0;
  logic [1:0]              seq_got = '0;

  utf8_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .buffer_last_i (buffer_last_i),
    .empty         (empty),
    .pop           (pop),
    .code_point_o  (code_point_o),
    .decode_error_o(decode_error_o),
    .run_last_o    (run_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  task automatic complain(string msg);
    // keep the log short on a badly broken design, but count everything
    if (errors < MaxPrinted) $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic note_cp(logic [usd_pkg::CpW-1:0] cp, logic err);
    cp_beat_t beat;
    beat.cp = cp;
    beat.err = err;
    beat.run_last = 1'b0;
    code_points_due.push_back(beat);
  endtask

  task automatic clear_seq();
    seq_value = '0;
    seq_need = '0;
    seq_got = '0;
  endtask

  // Predict the code point beats caused by one accepted byte
  task automatic decode_byte(logic [usd_pkg::ByteW-1:0] b, logic fin);
    int                      n_before;
    logic [usd_pkg::CpW-1:0] grown;
    n_before = code_points_due.size();
    if (seq_need == 2'd0) begin
      if ((b & usd_pkg::AsciiMask) == '0) begin
        note_cp(usd_pkg::CpW'(b), 1'b0);
      end else if (fin) begin
        note_cp(repl_char, 1'b1);
      end else if ((b & usd_pkg::Lead2Mask) == usd_pkg::Lead2Code) begin
        seq_value = usd_pkg::CpW'(b[4:0]);
        seq_need = 2'd1;
        seq_got = 2'd0;
      end else if ((b & usd_pkg::Lead3Mask) == usd_pkg::Lead3Code) begin
        seq_value = usd_pkg::CpW'(b[3:0]);
        seq_need = 2'd2;
        seq_got = 2'd0;
      end else if ((b & usd_pkg::Lead4Mask) == usd_pkg::Lead4Code) begin
        seq_value = usd_pkg::CpW'(b[2:0]);
        seq_need = 2'd3;
        seq_got = 2'd0;
      end else begin
        note_cp(repl_char, 1'b1);
      end
    end else if (fin && seq_need >= 2'd2) begin
      // buffer ends early: flag the lead and any continuation that came in, then decode b alone
      note_cp(repl_char, 1'b1);
      if (seq_got >= 2'd1) note_cp(repl_char, 1'b1);
      if ((b & usd_pkg::AsciiMask) == '0) note_cp(usd_pkg::CpW'(b), 1'b0);
      else note_cp(repl_char, 1'b1);
      clear_seq();
    end else if ((b & usd_pkg::ContMask) == usd_pkg::ContCode) begin
      grown = {seq_value[usd_pkg::CpW-7:0], b[5:0]};
      if (seq_need == 2'd1) begin
        note_cp(grown, 1'b0);
        clear_seq();
      end else begin
        seq_value = grown;
        seq_need = seq_need - 2'd1;
        seq_got = seq_got + 2'd1;
      end
    end else begin
      note_cp(repl_char, 1'b1);
      clear_seq();
    end
    // mark the closing beat of this byte's run
    if (code_points_due.size() > n_before)
      code_points_due[code_points_due.size() - 1].run_last = 1'b1;
  endtask

  // Driver: offer pending bytes, predict on each accepted beat
  always @(posedge clk_i) begin : drive_bytes
    byte_beat_t nxt;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_byte(data_byte_i, buffer_last_i);
        items_taken++;
      end
      if (!push || !full) begin
        if (byte_queue.size() != 0 && !(gaps_on && $urandom_range(99) < 33)) begin
          nxt = byte_queue.pop_front();
          push <= 1'b1;
          data_byte_i <= nxt.data;
          buffer_last_i <= nxt.fin;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result beat, pace pop, hold off once for a long stretch
  int   hold_left = 0;
  logic squeeze_done = 1'b0;

  always @(posedge clk_i) begin : watch_results
    cp_beat_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (code_points_due.size() == 0) begin
          complain($sformatf("unexpected beat cp=%h err=%b last=%b",
                             code_point_o, decode_error_o, run_last_o));
        end else begin
          want = code_points_due.pop_front();
          if (code_point_o !== want.cp || decode_error_o !== want.err ||
              run_last_o !== want.run_last)
            complain($sformatf("got cp=%h err=%b last=%b, want cp=%h err=%b last=%b",
                               code_point_o, decode_error_o, run_last_o,
                               want.cp, want.err, want.run_last));
        end
      end
      if (squeeze && !squeeze_done) begin
        hold_left = StallCycles;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !(gaps_on && $urandom_range(99) < 33);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("testbench: errors");
          $finish;
        end
      end
    end
  end

  task automatic queue_item(logic [usd_pkg::ByteW-1:0] b, logic fin);
    byte_beat_t beat;
    beat.data = b;
    beat.fin = fin;
    byte_queue.push_back(beat);
    items_queued++;
  endtask

  // Mostly well-formed sequences with random payload bits; some noise and truncation
  task automatic queue_random_run();
    int                        kind;
    int                        len;
    logic [usd_pkg::ByteW-1:0] b;
    kind = $urandom_range(99);
    if (kind < 15) begin
      queue_item(usd_pkg::ByteW'($urandom_range(255)), $urandom_range(9) == 0);
      return;
    end
    len = $urandom_range(1, 4);
    // shorten some sequences (the lead still matches the new length) and follow them with a random byte
    if (kind < 25 && len > 1) len = $urandom_range(1, len - 1) + 1;
    for (int k = 0; k < len; k++) begin
      b = usd_pkg::ByteW'($urandom_range(255));
      if (k == 0) begin
        case (len)
          1: b[7] = 1'b0;
          2: b[7:5] = 3'b110;
          3: b[7:4] = 4'b1110;
          default: b[7:3] = 5'b11110;
        endcase
      end else begin
        b[7:6] = 2'b10;
      end
      queue_item(b, $urandom_range(9) == 0);
    end
    if (kind < 25) queue_item(usd_pkg::ByteW'($urandom_range(255)), $urandom_range(9) == 0);
  endtask

  task automatic fill_random(int n_items);
    int target;
    target = items_queued + n_items;
    while (items_queued < target) queue_random_run();
  endtask

  // Wait until every byte is taken and every predicted beat has come out
  task automatic drain();
    while (items_taken != items_queued || code_points_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_repl(logic [usd_pkg::CpW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    repl_char = v;
  endtask

  // Sequencer
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ASCII extremes, stray bytes
    queue_item(8'h00, 1'b0);
    queue_item(8'h7f, 1'b1);
    queue_item(8'h80, 1'b0);
    queue_item(8'hff, 1'b0);
    // largest two-byte value, three-byte completed by the buffer's last byte
    queue_item(8'hdf, 1'b0);
    queue_item(8'hbf, 1'b0);
    queue_item(8'he2, 1'b0);
    queue_item(8'h82, 1'b0);
    queue_item(8'hac, 1'b1);
    // largest four-byte value, beyond the Unicode range
    queue_item(8'hf7, 1'b0);
    queue_item(8'hbf, 1'b0);
    queue_item(8'hbf, 1'b0);
    queue_item(8'hbf, 1'b0);
    // broken sequence, lead byte as the buffer's last byte
    queue_item(8'hc3, 1'b0);
    queue_item(8'h41, 1'b0);
    queue_item(8'hc3, 1'b1);
    // buffer ends early after one continuation, ending on a non-ASCII byte
    queue_item(8'hf0, 1'b0);
    queue_item(8'h90, 1'b0);
    queue_item(8'h80, 1'b1);
    // buffer ends early right after the lead, ending on an ASCII byte
    queue_item(8'he2, 1'b0);
    queue_item(8'h41, 1'b1);
    // broken in the middle of a four-byte sequence
    queue_item(8'hf4, 1'b0);
    queue_item(8'h8f, 1'b0);
    queue_item(8'h7e, 1'b0);
    fill_random(100);
    drain();

    // smallest replacement, no idling on either side
    write_repl('0);
    gaps_on <= 1'b0;
    fill_random(100);
    drain();

    // largest replacement, long receiver hold-off to fill the block
    write_repl({usd_pkg::CpW{1'b1}});
    gaps_on <= 1'b1;
    squeeze <= 1'b1;
    fill_random(150);
    drain();

    write_repl(usd_pkg::CpW'($urandom_range(0, 2097151)));
    fill_random(150);
    drain();

    repeat (20) @(posedge clk_i);
    while (code_points_due.size() != 0) begin
      cp_beat_t left;
      left = code_points_due.pop_front();
      complain($sformatf("missing beat cp=%h err=%b last=%b",
                         left.cp, left.err, left.run_last));
    end
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/usd_pkg.sv
hw/rtl/usd_fifo.sv
hw/rtl/usd_front.sv
hw/rtl/usd_back.sv
hw/rtl/utf8_stream_decoder.sv
verif/testbench.sv
